@@ rtl/pcpa_pkg.sv @@
package pcpa_pkg;

   localparam int CPUS       = 8;
   localparam int PAGES      = 1024;
   localparam int CPU_W      = 3;
   localparam int PAGE_W     = 10;
   localparam int PIDX_W     = $clog2(PAGES);
   localparam int PTR_W      = $clog2(PAGES) + 1;
   localparam int CNT_W      = $clog2(2 * PAGES);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [PTR_W-1:0]  EMPTY_MARK  = PTR_W'(PAGES);
   localparam logic [CNT_W-1:0]  COUNT_MAX   = CNT_W'(2 * PAGES - 1);
   localparam logic [CNT_W-1:0]  STEAL_MIN   = CNT_W'(3);
   localparam logic [PAGE_W-1:0] FIRST_RESET = '0;
   localparam logic [PTR_W-1:0]  LIMIT_RESET = PTR_W'(PAGES);

   typedef enum logic [0:0] {
      REG_FIRST_PAGE = 1'b0,
      REG_LIMIT_PAGE = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_WALK,
      ST_STEAL_RD,
      ST_STEAL_END
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_FREE,
      OP_POP_LAST,
      OP_POP_START,
      OP_POP_END,
      OP_STEAL_START,
      OP_WALK_STEP,
      OP_CUT,
      OP_STEAL_RD,
      OP_STEAL_END,
      OP_MISS
   } dp_op_type;

   typedef struct packed {
      logic is_alloc;
      logic local_nonempty;
      logic local_single;
      logic victim_found;
      logic walk_done;
      logic out_free;
   } dp_status_type;

endpackage

@@ rtl/per_cpu_page_allocator_steal_core.sv @@
// Per-CPU page allocator: eight LIFO free lists of page numbers sharing one
// 1024-entry link memory. Every request gives exactly one response transfer.
// A free (command 0) pushes the page on the CPU's list, or reports bad_free
// when the page lies outside [first_page, limit_page). An allocate (command 1)
// pops the CPU's own list; when that is empty it steals the back half of the
// lowest-numbered other list holding at least 3 pages, returns its first page
// and keeps the rest. Free, miss and a pop that empties the list respond straight
// from the execute state; a pop leaving pages first reads the next link; a steal
// makes one link-memory read per step of the walk to the split point. The next
// request is taken in the cycle after a response is written, even if that
// response is still waiting. The link memory is not cleared at reset. Write
// first_page and limit_page only while no request is outstanding.
module per_cpu_page_allocator_steal_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [pcpa_pkg::CPU_W-1:0]           req_cpu,
   input  logic [pcpa_pkg::PAGE_W-1:0]          req_page,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_granted,
   output logic [pcpa_pkg::PAGE_W-1:0]          rsp_out_page,
   output logic                                 rsp_bad_free,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pcpa_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pcpa_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pcpa_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   logic [pcpa_pkg::PAGE_W-1:0] first_page;
   logic [pcpa_pkg::PTR_W-1:0]  limit_page;
   pcpa_pkg::dp_op_type         op;
   pcpa_pkg::dp_status_type     status;

   pcpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .first_page  (first_page),
      .limit_page  (limit_page)
   );

   pcpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .op        (op)
   );

   pcpa_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .status       (status),
      .req_command  (req_command),
      .req_cpu      (req_cpu),
      .req_page     (req_page),
      .first_page   (first_page),
      .limit_page   (limit_page),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_granted  (rsp_granted),
      .rsp_out_page (rsp_out_page),
      .rsp_bad_free (rsp_bad_free)
   );

endmodule

@@ rtl/pcpa_csr.sv @@
module pcpa_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pcpa_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pcpa_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pcpa_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output logic [pcpa_pkg::PAGE_W-1:0]          first_page,
   output logic [pcpa_pkg::PTR_W-1:0]           limit_page
);

   logic [pcpa_pkg::PAGE_W-1:0] first_page_ff, first_page_in;
   logic [pcpa_pkg::PTR_W-1:0]  limit_page_ff, limit_page_in;
   pcpa_pkg::csr_reg_type       reg_sel;
   logic                        wr_en;

   assign reg_sel    = pcpa_pkg::csr_reg_type'(csr_paddr[2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign first_page = first_page_ff;
   assign limit_page = limit_page_ff;

   always_comb begin
      first_page_in = first_page_ff;
      limit_page_in = limit_page_ff;
      csr_prdata    = '0;
      unique case (reg_sel)
         pcpa_pkg::REG_FIRST_PAGE: begin
            csr_prdata = pcpa_pkg::CSR_DATA_W'(first_page_ff);
            if (wr_en) begin
               first_page_in = csr_pwdata[pcpa_pkg::PAGE_W-1:0];
            end
         end
         pcpa_pkg::REG_LIMIT_PAGE: begin
            csr_prdata = pcpa_pkg::CSR_DATA_W'(limit_page_ff);
            if (wr_en) begin
               limit_page_in = csr_pwdata[pcpa_pkg::PTR_W-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= pcpa_pkg::FIRST_RESET;
         limit_page_ff <= pcpa_pkg::LIMIT_RESET;
      end else begin
         first_page_ff <= first_page_in;
         limit_page_ff <= limit_page_in;
      end
   end

endmodule

@@ rtl/pcpa_ctrl.sv @@
module pcpa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pcpa_pkg::dp_status_type status,
   output pcpa_pkg::dp_op_type     op
);

   pcpa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcpa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = pcpa_pkg::OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         pcpa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = pcpa_pkg::OP_LATCH;
               state_in = pcpa_pkg::ST_EXEC;
            end
         end
         pcpa_pkg::ST_EXEC: begin
            // hold until the result register can take this transfer
            if (status.out_free) begin
               priority if (!status.is_alloc) begin
                  op       = pcpa_pkg::OP_FREE;
                  state_in = pcpa_pkg::ST_IDLE;
               end else if (status.local_nonempty && status.local_single) begin
                  op       = pcpa_pkg::OP_POP_LAST;
                  state_in = pcpa_pkg::ST_IDLE;
               end else if (status.local_nonempty) begin
                  op       = pcpa_pkg::OP_POP_START;
                  state_in = pcpa_pkg::ST_POP;
               end else if (status.victim_found) begin
                  op       = pcpa_pkg::OP_STEAL_START;
                  state_in = pcpa_pkg::ST_WALK;
               end else begin
                  op       = pcpa_pkg::OP_MISS;
                  state_in = pcpa_pkg::ST_IDLE;
               end
            end
         end
         pcpa_pkg::ST_POP: begin
            op       = pcpa_pkg::OP_POP_END;
            state_in = pcpa_pkg::ST_IDLE;
         end
         pcpa_pkg::ST_WALK: begin
            if (status.walk_done) begin
               op       = pcpa_pkg::OP_CUT;
               state_in = pcpa_pkg::ST_STEAL_RD;
            end else begin
               op = pcpa_pkg::OP_WALK_STEP;
            end
         end
         pcpa_pkg::ST_STEAL_RD: begin
            op       = pcpa_pkg::OP_STEAL_RD;
            state_in = pcpa_pkg::ST_STEAL_END;
         end
         pcpa_pkg::ST_STEAL_END: begin
            op       = pcpa_pkg::OP_STEAL_END;
            state_in = pcpa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/pcpa_dp.sv @@
module pcpa_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  pcpa_pkg::dp_op_type             op,
   output pcpa_pkg::dp_status_type         status,
   input  logic                            req_command,
   input  logic [pcpa_pkg::CPU_W-1:0]      req_cpu,
   input  logic [pcpa_pkg::PAGE_W-1:0]     req_page,
   input  logic [pcpa_pkg::PAGE_W-1:0]     first_page,
   input  logic [pcpa_pkg::PTR_W-1:0]      limit_page,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_granted,
   output logic [pcpa_pkg::PAGE_W-1:0]     rsp_out_page,
   output logic                            rsp_bad_free
);

   logic [pcpa_pkg::PTR_W-1:0] link_mem [pcpa_pkg::PAGES];

   logic [pcpa_pkg::PTR_W-1:0]  head_ff  [pcpa_pkg::CPUS];
   logic [pcpa_pkg::PTR_W-1:0]  head_in  [pcpa_pkg::CPUS];
   logic [pcpa_pkg::CNT_W-1:0]  count_ff [pcpa_pkg::CPUS];
   logic [pcpa_pkg::CNT_W-1:0]  count_in [pcpa_pkg::CPUS];

   logic                        command_ff;
   logic [pcpa_pkg::CPU_W-1:0]  cpu_ff;
   logic [pcpa_pkg::PAGE_W-1:0] page_ff;
   logic [pcpa_pkg::PTR_W-1:0]  cur_ff, cur_in;
   logic [pcpa_pkg::CNT_W-1:0]  remain_ff, remain_in;
   logic [pcpa_pkg::PTR_W-1:0]  rdata_ff;
   logic                        roob_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_granted_ff;
   logic [pcpa_pkg::PAGE_W-1:0] rsp_out_page_ff;
   logic                        rsp_bad_free_ff;

   logic                        rd_en;
   logic [pcpa_pkg::PTR_W-1:0]  raddr;
   logic                        wr_en;
   logic [pcpa_pkg::PIDX_W-1:0] waddr;
   logic [pcpa_pkg::PTR_W-1:0]  wdata;

   logic                        emit;
   logic                        emit_granted;
   logic [pcpa_pkg::PTR_W-1:0]  emit_page;
   logic                        emit_bad;

   logic [pcpa_pkg::CNT_W-1:0]  n_local;
   logic [pcpa_pkg::PTR_W-1:0]  head_local;
   logic                        victim_found;
   logic [pcpa_pkg::CPU_W-1:0]  victim;
   logic [pcpa_pkg::CNT_W-1:0]  n_victim;
   logic [pcpa_pkg::CNT_W:0]    keep_wide;
   logic [pcpa_pkg::PTR_W-1:0]  link;
   logic                        bad_page;
   logic                        out_free;

   assign n_local    = count_ff[cpu_ff];
   assign head_local = head_ff[cpu_ff];
   assign n_victim   = count_ff[victim];
   assign keep_wide  = ({1'b0, n_victim} + (pcpa_pkg::CNT_W + 1)'(1)) >> 1;
   assign link       = (roob_ff || rdata_ff >= pcpa_pkg::EMPTY_MARK) ?
                       pcpa_pkg::EMPTY_MARK : rdata_ff;
   assign bad_page   = (page_ff < first_page) ||
                       (pcpa_pkg::PTR_W'(page_ff) >= limit_page) ||
                       (pcpa_pkg::PTR_W'(page_ff) >= pcpa_pkg::EMPTY_MARK);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // lowest-numbered other CPU holding enough pages
   always_comb begin
      victim_found = 1'b0;
      victim       = '0;
      for (int v = pcpa_pkg::CPUS - 1; v >= 0; v--) begin
         if (pcpa_pkg::CPU_W'(v) != cpu_ff && count_ff[v] >= pcpa_pkg::STEAL_MIN) begin
            victim_found = 1'b1;
            victim       = pcpa_pkg::CPU_W'(v);
         end
      end
   end

   always_comb begin
      status.is_alloc       = command_ff;
      status.local_nonempty = n_local != '0;
      status.local_single   = n_local == pcpa_pkg::CNT_W'(1);
      status.victim_found   = victim_found;
      status.walk_done      = remain_ff == '0;
      status.out_free       = out_free;
   end

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      remain_in    = remain_ff;
      rd_en        = 1'b0;
      raddr        = '0;
      wr_en        = 1'b0;
      waddr        = '0;
      wdata        = '0;
      emit         = 1'b0;
      emit_granted = 1'b0;
      emit_page    = '0;
      emit_bad     = 1'b0;
      unique case (op)
         pcpa_pkg::OP_NONE, pcpa_pkg::OP_LATCH: begin
         end
         pcpa_pkg::OP_FREE: begin
            emit = 1'b1;
            if (bad_page) begin
               emit_bad = 1'b1;
            end else begin
               wr_en           = 1'b1;
               waddr           = page_ff[pcpa_pkg::PIDX_W-1:0];
               wdata           = head_local;
               head_in[cpu_ff] = pcpa_pkg::PTR_W'(page_ff);
               if (n_local < pcpa_pkg::COUNT_MAX) begin
                  count_in[cpu_ff] = n_local + pcpa_pkg::CNT_W'(1);
               end
            end
         end
         pcpa_pkg::OP_POP_LAST: begin
            emit             = 1'b1;
            emit_granted     = 1'b1;
            emit_page        = head_local;
            count_in[cpu_ff] = '0;
            head_in[cpu_ff]  = pcpa_pkg::EMPTY_MARK;
         end
         pcpa_pkg::OP_POP_START: begin
            cur_in           = head_local;
            count_in[cpu_ff] = n_local - pcpa_pkg::CNT_W'(1);
            rd_en            = 1'b1;
            raddr            = head_local;
         end
         pcpa_pkg::OP_POP_END: begin
            head_in[cpu_ff] = link;
            emit            = 1'b1;
            emit_granted    = 1'b1;
            emit_page       = cur_ff;
         end
         pcpa_pkg::OP_STEAL_START: begin
            cur_in           = head_ff[victim];
            remain_in        = (n_victim - pcpa_pkg::CNT_W'(1)) >> 1;
            count_in[victim] = keep_wide[pcpa_pkg::CNT_W-1:0];
            count_in[cpu_ff] = (n_victim >> 1) - pcpa_pkg::CNT_W'(1);
            rd_en            = 1'b1;
            raddr            = head_ff[victim];
         end
         pcpa_pkg::OP_WALK_STEP: begin
            cur_in    = link;
            remain_in = remain_ff - pcpa_pkg::CNT_W'(1);
            rd_en     = 1'b1;
            raddr     = link;
         end
         pcpa_pkg::OP_CUT: begin
            // cur holds the last kept page, link is the first stolen one
            cur_in = link;
            if (cur_ff < pcpa_pkg::EMPTY_MARK) begin
               wr_en = 1'b1;
               waddr = cur_ff[pcpa_pkg::PIDX_W-1:0];
               wdata = pcpa_pkg::EMPTY_MARK;
            end
         end
         pcpa_pkg::OP_STEAL_RD: begin
            rd_en = 1'b1;
            raddr = cur_ff;
         end
         pcpa_pkg::OP_STEAL_END: begin
            head_in[cpu_ff] = (n_local != '0) ? link : pcpa_pkg::EMPTY_MARK;
            emit            = 1'b1;
            emit_granted    = 1'b1;
            emit_page       = cur_ff;
         end
         pcpa_pkg::OP_MISS: begin
            emit = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= link_mem[raddr[pcpa_pkg::PIDX_W-1:0]];
         roob_ff  <= raddr >= pcpa_pkg::EMPTY_MARK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pcpa_pkg::CPUS; i++) begin
            head_ff[i]  <= pcpa_pkg::EMPTY_MARK;
            count_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      remain_ff <= remain_in;
      if (op == pcpa_pkg::OP_LATCH) begin
         command_ff <= req_command;
         cpu_ff     <= req_cpu;
         page_ff    <= req_page;
      end
      if (emit) begin
         rsp_granted_ff  <= emit_granted;
         rsp_out_page_ff <= emit_granted ? emit_page[pcpa_pkg::PAGE_W-1:0] : '0;
         rsp_bad_free_ff <= emit_bad;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_granted  = rsp_granted_ff;
   assign rsp_out_page = rsp_out_page_ff;
   assign rsp_bad_free = rsp_bad_free_ff;

endmodule
